// ----- hw/rtl/rrtt_pkg.sv -----
// Shared constants, codes and transaction types for the round-robin task table.
package rrtt_pkg;

  // Table depth and the widths that follow from it.
  localparam int MAX_TASKS = 4;
  localparam int POS_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths.
  localparam int ACTION_W = 2;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 3;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_CREATE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DISPATCH = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADID   = 3'd5;

  // One request as held in the input register.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     task_id;
  } req_t;

  // One result as held in the result register.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     task_out;
    logic [COUNT_W-1:0]  task_count;
  } rsp_t;

endpackage

// ----- hw/rtl/rrtt_req_if.sv -----
// Request channel: valid/ready handshake carrying an action and a task identifier.
interface rrtt_req_if import rrtt_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     task_id;

  modport source (output valid, action, task_id, input ready);
  modport sink   (input valid, action, task_id, output ready);

endinterface

// ----- hw/rtl/rrtt_rsp_if.sv -----
// Result channel: valid/ready handshake carrying status, dispatched task and count.
interface rrtt_rsp_if import rrtt_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     task_out;
  logic [COUNT_W-1:0]  task_count;

  modport source (output valid, status, task_out, task_count, input ready);
  modport sink   (input valid, status, task_out, task_count, output ready);

endinterface

// ----- hw/rtl/rrtt_in_reg.sv -----
// Input register: captures one request transaction and holds it until it is processed.
module rrtt_in_reg import rrtt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rrtt_req_if.sink     req,
  input  logic         advance,
  output logic         valid,
  output req_t         data
);

  logic valid_next;

  // The register can take a new transaction when empty or when its content moves on,
  // and takes none while reset is held.
  assign req.ready = !rst && (!valid || advance);

  always_comb begin
    if (req.valid && req.ready) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      data.action  <= req.action;
      data.task_id <= req.task_id;
    end
  end

endmodule

// ----- hw/rtl/rrtt_table.sv -----
// Task table state with the combinational create, delete and dispatch logic.
module rrtt_table import rrtt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp
);

  logic [ID_W-1:0]  task_list      [MAX_TASKS];
  logic [ID_W-1:0]  task_list_next [MAX_TASKS];
  logic [ID_W-1:0]  shifted        [MAX_TASKS];
  logic [CNT_W-1:0] length;
  logic [CNT_W-1:0] length_next;
  logic [POS_W-1:0] run_pos;
  logic [POS_W-1:0] run_pos_next;
  logic [MAX_TASKS-1:0] hit;
  logic [MAX_TASKS-1:0] at_or_above;
  logic                 found;
  logic [POS_W-1:0]     run_eff;
  logic [CNT_W-1:0]     run_inc;
  logic [STATUS_W-1:0]  status;
  logic [ID_W-1:0]      chosen;

  // Parallel compare against every listed entry.
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      hit[i] = (CNT_W'(i) < length) && (task_list[i] == req.task_id);
    end
  end

  assign found = |hit;

  // Entries at or above the matching one take part in the shift down.
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      at_or_above[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        at_or_above[i] = at_or_above[i] | hit[j];
      end
    end
  end

  // The list moved down by one place, with zero entering at the top.
  always_comb begin
    for (int i = 0; i < MAX_TASKS - 1; i++) begin
      shifted[i] = task_list[i+1];
    end
    shifted[MAX_TASKS-1] = '0;
  end

  // Run position, wrapped to the first entry when deletes left it past the end.
  always_comb begin
    run_eff = (CNT_W'(run_pos) >= length) ? '0 : run_pos;
    run_inc = CNT_W'(run_eff) + CNT_W'(1);
  end

  // Action decode and next state.
  always_comb begin
    task_list_next = task_list;
    length_next    = length;
    run_pos_next   = run_pos;
    status         = ST_DONE;
    chosen         = '0;
    case (req.action)
      ACT_CREATE: begin
        if (req.task_id == '0) begin
          status = ST_BADID;
        end else if (found) begin
          status = ST_PRESENT;
        end else if (length >= CNT_W'(MAX_TASKS)) begin
          status = ST_FULL;
        end else begin
          for (int i = 0; i < MAX_TASKS; i++) begin
            if (CNT_W'(i) == length) begin
              task_list_next[i] = req.task_id;
            end
          end
          length_next = length + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (req.task_id == '0) begin
          status = ST_BADID;
        end else if (!found) begin
          status = ST_MISSING;
        end else begin
          for (int i = 0; i < MAX_TASKS; i++) begin
            if (at_or_above[i]) begin
              task_list_next[i] = shifted[i];
            end
          end
          length_next = length - CNT_W'(1);
        end
      end
      ACT_DISPATCH: begin
        if (length == '0) begin
          status       = ST_EMPTY;
          run_pos_next = '0;
        end else begin
          chosen       = task_list[run_eff];
          run_pos_next = (run_inc >= length) ? '0 : run_inc[POS_W-1:0];
        end
      end
      default: begin
        // Unused action code: no change, plain done status.
        status = ST_DONE;
      end
    endcase
  end

  assign rsp.status     = status;
  assign rsp.task_out   = chosen;
  assign rsp.task_count = COUNT_W'(length_next);

  // State update when the transaction moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      length  <= '0;
      run_pos <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        task_list[i] <= '0;
      end
    end else if (fire) begin
      length    <= length_next;
      run_pos   <= run_pos_next;
      task_list <= task_list_next;
    end
  end

  // Listed entries are nonzero and the unused tail is kept at zero.
  logic [MAX_TASKS-1:0] layout_ok;
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      layout_ok[i] = (CNT_W'(i) < length) ? (task_list[i] != '0) : (task_list[i] == '0);
    end
  end

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= CNT_W'(MAX_TASKS))
    else $error("task count exceeds table depth");

  a_layout: assert property (@(posedge clk) disable iff (rst)
    &layout_ok)
    else $error("task list is not compacted");

  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    fire && req.action == ACT_CREATE && status == ST_DONE
    |=> length == $past(length) + CNT_W'(1))
    else $error("successful create did not add an entry");

  a_dispatch_nonzero: assert property (@(posedge clk) disable iff (rst)
    fire && req.action == ACT_DISPATCH && status == ST_DONE |-> chosen != '0)
    else $error("dispatch returned an empty entry");

endmodule

// ----- hw/rtl/rrtt_out_reg.sv -----
// Result register: holds one result transaction until the sink takes it.
module rrtt_out_reg import rrtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  rsp_t        data,
  output logic        can_load,
  rrtt_rsp_if.source  rsp
);

  logic valid;
  logic valid_next;
  rsp_t held;

  // A new result may enter when the register is empty or is being emptied.
  assign can_load = !valid || rsp.ready;

  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (rsp.ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign rsp.valid      = valid;
  assign rsp.status     = held.status;
  assign rsp.task_out   = held.task_out;
  assign rsp.task_count = held.task_count;

endmodule

// ----- hw/rtl/round_robin_task_table_core.sv -----
// A request waits in the input register until the result register can take its result.
// One request per cycle while results are taken; compare-and-shift is combinational.
// A stalled result holds in the result register while one more request waits at the input.
// Reset (synchronous, active high) empties the table, zeroes the run position and
// clears both registers; requests are accepted from the first cycle after reset.
module round_robin_task_table_core import rrtt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rrtt_req_if.sink   req,
  rrtt_rsp_if.source rsp
);

  logic in_valid;
  req_t in_data;
  rsp_t result;
  logic can_load;
  logic advance;

  // A held request is processed when the result register can take its result.
  assign advance = in_valid && can_load;

  rrtt_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .valid   (in_valid),
    .data    (in_data)
  );

  rrtt_table u_table (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (in_data),
    .rsp  (result)
  );

  rrtt_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .data     (result),
    .can_load (can_load),
    .rsp      (rsp)
  );

endmodule

// ----- sim/round_robin_task_table_core_tb.sv -----
// Self-checking testbench for the round-robin task table core.
`timescale 1ns / 100ps

module round_robin_task_table_core_tb;
  import rrtt_pkg::*;

  // The spare action code, which the table ignores.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 22;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_N       = 6;
  localparam int REPORT_MAX   = 10;

  logic clk;
  logic rst;

  rrtt_req_if req_ch ();
  rrtt_rsp_if rsp_ch ();

  round_robin_task_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted table contents, length and run position.
  logic [ID_W-1:0] roster [MAX_TASKS];
  int              roster_len = 0;
  int              turn_pos   = 0;

  rsp_t            expected_q [$];
  int              mismatches  = 0;
  int              stall_count = 0;
  bit              no_idle     = 1'b0;
  logic [ID_W-1:0] id_pool [POOL_N];

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the result of one request and updates the predicted table.
  function automatic rsp_t predict_outcome(input logic [ACTION_W-1:0] act,
                                           input logic [ID_W-1:0] id);
    rsp_t outcome;
    int   slot;
    outcome.status   = ST_DONE;
    outcome.task_out = '0;
    slot = roster_len;
    for (int i = roster_len - 1; i >= 0; i--) begin
      if (roster[i] == id) slot = i;
    end
    case (act)
      ACT_CREATE: begin
        if (id == '0) outcome.status = ST_BADID;
        else if (slot < roster_len) outcome.status = ST_PRESENT;
        else if (roster_len >= MAX_TASKS) outcome.status = ST_FULL;
        else begin
          roster[roster_len] = id;
          roster_len++;
        end
      end
      ACT_DELETE: begin
        if (id == '0) outcome.status = ST_BADID;
        else if (slot >= roster_len) outcome.status = ST_MISSING;
        else begin
          for (int i = slot; i + 1 < roster_len; i++) roster[i] = roster[i + 1];
          roster_len--;
          roster[roster_len] = '0;
        end
      end
      ACT_DISPATCH: begin
        if (roster_len == 0) begin
          outcome.status = ST_EMPTY;
          turn_pos = 0;
        end else begin
          if (turn_pos >= roster_len) turn_pos = 0;
          outcome.task_out = roster[turn_pos];
          turn_pos++;
          if (turn_pos >= roster_len) turn_pos = 0;
        end
      end
      default: begin
      end
    endcase
    outcome.task_count = COUNT_W'(roster_len);
    return outcome;
  endfunction

  // Counts a failure and reports the first few of them.
  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("MISMATCH at %0t ns: %s", $time, msg);
  endfunction

  // Checks each result transaction, then records each accepted request.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d task_out %0d count %0d",
                                 rsp_ch.status, rsp_ch.task_out, rsp_ch.task_count));
        end else begin
          want = expected_q.pop_front();
          if (rsp_ch.status !== want.status)
            note_failure($sformatf("status expected %0d got %0d",
                                   want.status, rsp_ch.status));
          if (rsp_ch.task_out !== want.task_out)
            note_failure($sformatf("task_out expected %0d got %0d",
                                   want.task_out, rsp_ch.task_out));
          if (rsp_ch.task_count !== want.task_count)
            note_failure($sformatf("task_count expected %0d got %0d",
                                   want.task_count, rsp_ch.task_count));
        end
      end
      if (req_ch.valid && req_ch.ready)
        expected_q.push_back(predict_outcome(req_ch.action, req_ch.task_id));
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
    end
  end

  // The result side stalls at random unless back-to-back traffic is running.
  always @(negedge clk) begin
    rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Ends the run when nothing has moved for too long.
  initial begin
    wait (stall_count >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one request, with random gaps before it, and waits for its transaction.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.task_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Sends one random request, mostly using identifiers from a small pool.
  task automatic send_random_item();
    int              pick;
    logic [ACTION_W-1:0] act;
    logic [ID_W-1:0] id;
    pick = $urandom_range(99);
    if (pick < 35) act = ACT_CREATE;
    else if (pick < 60) act = ACT_DELETE;
    else if (pick < 95) act = ACT_DISPATCH;
    else act = ACT_UNUSED;
    pick = $urandom_range(99);
    if (pick < 80) id = id_pool[$urandom_range(POOL_N - 1)];
    else if (pick < 85) id = '0;
    else id = ID_W'($urandom_range(255));
    send_item(act, id);
  endtask

  // Draws a fresh set of nonzero identifiers for the random traffic.
  task automatic refresh_pool();
    for (int i = 0; i < POOL_N; i++) id_pool[i] = ID_W'($urandom_range(255, 1));
  endtask

  // Holds off the sender until every pending result has arrived.
  task automatic wait_for_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Field extremes, every action and each corner case of the table.
  task automatic test_directed();
    send_item(ACT_DISPATCH, 8'h00);   // dispatch from an empty table
    send_item(ACT_CREATE,   8'h00);   // zero identifier
    send_item(ACT_DELETE,   8'h00);
    send_item(ACT_DELETE,   8'h11);   // not listed
    send_item(ACT_UNUSED,   8'hFF);   // ignored action
    send_item(ACT_CREATE,   8'hFF);
    send_item(ACT_CREATE,   8'h01);
    send_item(ACT_CREATE,   8'hFF);   // already listed
    send_item(ACT_CREATE,   8'hAA);
    send_item(ACT_CREATE,   8'h55);
    send_item(ACT_CREATE,   8'h80);   // table full
    send_item(ACT_DISPATCH, 8'hC3);   // identifier ignored on dispatch
    send_item(ACT_DISPATCH, 8'h00);
    send_item(ACT_DISPATCH, 8'h00);
    send_item(ACT_DELETE,   8'h55);   // run position now past the end
    send_item(ACT_DISPATCH, 8'h00);   // wraps to the first entry
    send_item(ACT_DELETE,   8'hFF);   // delete at the head shifts the rest down
    send_item(ACT_DISPATCH, 8'h00);
    send_item(ACT_DELETE,   8'h7E);
    send_item(ACT_DELETE,   8'h01);
    send_item(ACT_DELETE,   8'hAA);
    send_item(ACT_UNUSED,   8'h00);
    send_item(ACT_DISPATCH, 8'h00);
    send_item(ACT_CREATE,   8'h80);
    send_item(ACT_DISPATCH, 8'h00);   // single entry wraps onto itself
    send_item(ACT_DISPATCH, 8'h00);
  endtask

  // Random traffic with idling on both sides.
  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) refresh_pool();
      send_random_item();
    end
  endtask

  // A burst of traffic, then a pause until the table has answered everything.
  task automatic test_pause_until_drained();
    refresh_pool();
    for (int n = 0; n < 30; n++) send_random_item();
    wait_for_drain();
    for (int n = 0; n < 10; n++) send_random_item();
  endtask

  // A long stretch with no idling on either side.
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    refresh_pool();
    for (int n = 0; n < count; n++) send_random_item();
    no_idle = 1'b0;
  endtask

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_CREATE;
    req_ch.task_id = '0;
    rsp_ch.ready   = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) roster[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    wait_for_drain();
    test_random_traffic(250);
    test_pause_until_drained();
    test_back_to_back(150);
    test_random_traffic(150);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- round_robin_task_table_core.f -----
hw/rtl/rrtt_pkg.sv
hw/rtl/rrtt_req_if.sv
hw/rtl/rrtt_rsp_if.sv
hw/rtl/rrtt_in_reg.sv
hw/rtl/rrtt_table.sv
hw/rtl/rrtt_out_reg.sv
hw/rtl/round_robin_task_table_core.sv
sim/round_robin_task_table_core_tb.sv
